// File: sv/bsa_pkg.sv
package bsa_pkg;

    // block sizing
    localparam int NUM_PROC   = 5;
    localparam int NUM_RES    = 3;
    localparam int COUNT_BITS = 8;
    localparam int FIELD_BITS = 8;
    localparam int PROC_BITS  = (NUM_PROC > 1) ? $clog2(NUM_PROC) : 1;
    localparam int CNT_BITS   = $clog2(NUM_PROC + 1);
    localparam int WORK_BITS  = COUNT_BITS + $clog2(NUM_PROC + 1);

    // command codes
    localparam logic [1:0] CMD_LOAD_ROW  = 2'd0;
    localparam logic [1:0] CMD_LOAD_FREE = 2'd1;
    localparam logic [1:0] CMD_REQUEST   = 2'd2;

    // status codes
    localparam logic [2:0] ST_GRANTED    = 3'd0;
    localparam logic [2:0] ST_OVER_NEED  = 3'd1;
    localparam logic [2:0] ST_NO_FREE    = 3'd2;
    localparam logic [2:0] ST_UNSAFE     = 3'd3;
    localparam logic [2:0] ST_LOAD_DONE  = 3'd4;

    typedef logic [COUNT_BITS-1:0]                count_t;
    typedef logic [WORK_BITS-1:0]                 work_t;
    typedef logic [PROC_BITS-1:0]                 proc_t;
    typedef logic [CNT_BITS-1:0]                  cnt_t;
    typedef logic [NUM_RES-1:0][COUNT_BITS-1:0]   row_t;
    typedef logic [NUM_RES-1:0][WORK_BITS-1:0]    work_vec_t;

    // result of the merge stage
    typedef struct packed {
        logic                found;
        proc_t               idx;
        logic [NUM_PROC-1:0] onehot;
    } pick_t;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_SCAN,
        S_EMIT,
        S_REJECT
    } state_t;

    // field to count width
    function automatic count_t to_count(input logic [FIELD_BITS-1:0] v);
        return COUNT_BITS'(v);
    endfunction

endpackage

// File: sv/bsa_in_if.sv
interface bsa_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] cmd;
    logic [2:0] proc_id;
    logic [7:0] amount_a;
    logic [7:0] amount_b;
    logic [7:0] amount_c;
    logic [7:0] need_a;
    logic [7:0] need_b;
    logic [7:0] need_c;

    modport source (
        output valid, cmd, proc_id, amount_a, amount_b, amount_c, need_a, need_b, need_c,
        input  ready
    );
    modport sink (
        input  valid, cmd, proc_id, amount_a, amount_b, amount_c, need_a, need_b, need_c,
        output ready
    );
endinterface

// File: sv/bsa_out_if.sv
interface bsa_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] status;
    logic [2:0] seq_process;
    logic       last;

    modport source (
        output valid, status, seq_process, last,
        input  ready
    );
    modport sink (
        input  valid, status, seq_process, last,
        output ready
    );
endinterface

// File: sv/bankers_safety_allocator.sv
// Banker's-algorithm allocator for NUM_PROC processes and three resource types. One item is
// taken at a time: a load or a refused request passes an accept step and a decide step and
// gives one result. A request that passes the need and free checks is granted tentatively and
// the safety check runs on the lane array, one process finished per cycle, until every process
// has finished or none fits; a safe grant then delivers NUM_PROC results, one per cycle while
// the output is not held by back-pressure, while an unsafe grant is rolled back and reports
// one result. The scan length is set by the chain of finishing processes, each of which
// widens the work vector for the next. A new item can be taken while the last result of the
// previous one still waits in the output register.
// Reset clears the free vector and all allocation and need rows.
module bankers_safety_allocator (
    input  logic        clk,
    input  logic        rst_n,
    bsa_in_if.sink      items,
    bsa_out_if.source   results
);

    // state
    bsa_pkg::state_t    state_reg, state_next;
    logic [1:0]         cmd_reg;
    logic [2:0]         pid_reg;
    bsa_pkg::row_t      amt_reg;
    bsa_pkg::row_t      nd_reg;

    bsa_pkg::row_t      free_reg;
    bsa_pkg::row_t      alloc_reg [bsa_pkg::NUM_PROC];
    bsa_pkg::row_t      need_reg  [bsa_pkg::NUM_PROC];
    bsa_pkg::row_t      save_free_reg, save_alloc_reg, save_need_reg;

    bsa_pkg::work_vec_t          work_reg;
    logic [bsa_pkg::NUM_PROC-1:0] done_reg;
    bsa_pkg::cnt_t               count_reg;
    bsa_pkg::proc_t              cursor_reg;
    bsa_pkg::proc_t              order_reg [bsa_pkg::NUM_PROC];
    bsa_pkg::proc_t              emit_idx_reg;

    logic               out_valid_reg;
    logic [2:0]         status_reg;
    logic [2:0]         seq_reg;
    logic               last_reg;

    // control
    logic               out_free;
    logic               pid_ok;
    bsa_pkg::proc_t     row_idx;
    logic               over_need, over_free;
    bsa_pkg::row_t      alloc_sat;
    logic               emit;
    logic [2:0]         emit_status;
    logic [2:0]         emit_seq;
    logic               emit_last;
    logic               wr_row, wr_free, grant_apply, rollback, scan_step, emit_step;

    // lanes and merge
    logic [bsa_pkg::NUM_PROC-1:0] fits;
    bsa_pkg::row_t               contrib [bsa_pkg::NUM_PROC];
    bsa_pkg::pick_t              pick;
    bsa_pkg::work_vec_t          work_sum;

    assign out_free = !out_valid_reg || results.ready;
    assign items.ready = (state_reg == bsa_pkg::S_IDLE);

    // row selection for the request checks
    assign pid_ok  = (32'(pid_reg) < bsa_pkg::NUM_PROC);
    assign row_idx = pid_ok ? bsa_pkg::PROC_BITS'(pid_reg) : '0;

    always_comb
    begin
        over_need = !pid_ok;
        over_free = 1'b0;
        for (int r = 0; r < bsa_pkg::NUM_RES; r++)
        begin
            logic [bsa_pkg::COUNT_BITS:0] sum;
            sum = {1'b0, alloc_reg[row_idx][r]} + {1'b0, amt_reg[r]};
            alloc_sat[r] = sum[bsa_pkg::COUNT_BITS] ? '1 : sum[bsa_pkg::COUNT_BITS-1:0];
            if (amt_reg[r] > need_reg[row_idx][r])
                over_need = 1'b1;
            if (amt_reg[r] > free_reg[r])
                over_free = 1'b1;
        end
    end

    // one lane per process
    for (genvar i = 0; i < bsa_pkg::NUM_PROC; i++)
    begin : g_lane
        bsa_lane u_lane (
            .need    (need_reg[i]),
            .alloc   (alloc_reg[i]),
            .work    (work_reg),
            .done    (done_reg[i]),
            .pick    (pick.onehot[i]),
            .fits    (fits[i]),
            .contrib (contrib[i])
        );
    end

    bsa_merge u_merge (
        .fits     (fits),
        .cursor   (cursor_reg),
        .contrib  (contrib),
        .work     (work_reg),
        .pick     (pick),
        .work_sum (work_sum)
    );

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        emit        = 1'b0;
        emit_status = bsa_pkg::ST_LOAD_DONE;
        emit_seq    = '0;
        emit_last   = 1'b1;
        wr_row      = 1'b0;
        wr_free     = 1'b0;
        grant_apply = 1'b0;
        rollback    = 1'b0;
        scan_step   = 1'b0;
        emit_step   = 1'b0;
        unique case (state_reg)
            bsa_pkg::S_IDLE:
            begin
                if (items.valid)
                    state_next = bsa_pkg::S_DECIDE;
            end
            bsa_pkg::S_DECIDE:
            begin
                if (out_free)
                begin
                    state_next = bsa_pkg::S_IDLE;
                    if (cmd_reg == bsa_pkg::CMD_LOAD_ROW)
                    begin
                        wr_row = pid_ok;
                        emit   = 1'b1;
                    end
                    else if (cmd_reg == bsa_pkg::CMD_LOAD_FREE)
                    begin
                        wr_free = 1'b1;
                        emit    = 1'b1;
                    end
                    else if (cmd_reg != bsa_pkg::CMD_REQUEST)
                    begin
                        emit = 1'b1;
                    end
                    else if (over_need)
                    begin
                        emit        = 1'b1;
                        emit_status = bsa_pkg::ST_OVER_NEED;
                    end
                    else if (over_free)
                    begin
                        emit        = 1'b1;
                        emit_status = bsa_pkg::ST_NO_FREE;
                    end
                    else
                    begin
                        grant_apply = 1'b1;
                        state_next  = bsa_pkg::S_SCAN;
                    end
                end
            end
            bsa_pkg::S_SCAN:
            begin
                if (pick.found)
                begin
                    scan_step = 1'b1;
                    if (count_reg == bsa_pkg::CNT_BITS'(bsa_pkg::NUM_PROC - 1))
                        state_next = bsa_pkg::S_EMIT;
                end
                else
                begin
                    rollback   = 1'b1;
                    state_next = bsa_pkg::S_REJECT;
                end
            end
            bsa_pkg::S_EMIT:
            begin
                if (out_free)
                begin
                    emit        = 1'b1;
                    emit_step   = 1'b1;
                    emit_status = bsa_pkg::ST_GRANTED;
                    emit_seq    = 3'(order_reg[emit_idx_reg]);
                    emit_last   = (emit_idx_reg == bsa_pkg::PROC_BITS'(bsa_pkg::NUM_PROC - 1));
                    if (emit_last)
                        state_next = bsa_pkg::S_IDLE;
                end
            end
            bsa_pkg::S_REJECT:
            begin
                if (out_free)
                begin
                    emit        = 1'b1;
                    emit_status = bsa_pkg::ST_UNSAFE;
                    state_next  = bsa_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = bsa_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= bsa_pkg::S_IDLE;
        else
            state_reg <= state_next;
    end

    // input capture on transfer
    always_ff @(posedge clk)
    begin
        if (items.valid && items.ready)
        begin
            cmd_reg    <= items.cmd;
            pid_reg    <= items.proc_id;
            amt_reg[0] <= bsa_pkg::to_count(items.amount_a);
            amt_reg[1] <= bsa_pkg::to_count(items.amount_b);
            amt_reg[2] <= bsa_pkg::to_count(items.amount_c);
            nd_reg[0]  <= bsa_pkg::to_count(items.need_a);
            nd_reg[1]  <= bsa_pkg::to_count(items.need_b);
            nd_reg[2]  <= bsa_pkg::to_count(items.need_c);
        end
    end

    // free vector and process tables
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_reg <= '0;
            for (int i = 0; i < bsa_pkg::NUM_PROC; i++)
            begin
                alloc_reg[i] <= '0;
                need_reg[i]  <= '0;
            end
        end
        else
        begin
            if (wr_row)
            begin
                alloc_reg[row_idx] <= amt_reg;
                need_reg[row_idx]  <= nd_reg;
            end
            if (wr_free)
                free_reg <= amt_reg;
            if (grant_apply)
            begin
                for (int r = 0; r < bsa_pkg::NUM_RES; r++)
                begin
                    free_reg[r]          <= free_reg[r] - amt_reg[r];
                    need_reg[row_idx][r] <= need_reg[row_idx][r] - amt_reg[r];
                end
                alloc_reg[row_idx] <= alloc_sat;
            end
            if (rollback)
            begin
                free_reg           <= save_free_reg;
                alloc_reg[row_idx] <= save_alloc_reg;
                need_reg[row_idx]  <= save_need_reg;
            end
        end
    end

    // rollback copy and scan work vector
    always_ff @(posedge clk)
    begin
        if (grant_apply)
        begin
            save_free_reg  <= free_reg;
            save_alloc_reg <= alloc_reg[row_idx];
            save_need_reg  <= need_reg[row_idx];
            for (int r = 0; r < bsa_pkg::NUM_RES; r++)
                work_reg[r] <= bsa_pkg::WORK_BITS'(free_reg[r] - amt_reg[r]);
        end
        else if (scan_step)
        begin
            work_reg <= work_sum;
        end
        if (scan_step)
            order_reg[count_reg[bsa_pkg::PROC_BITS-1:0]] <= pick.idx;
    end

    // scan progress
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg     <= '0;
            count_reg    <= '0;
            cursor_reg   <= '0;
            emit_idx_reg <= '0;
        end
        else
        begin
            if (grant_apply)
            begin
                done_reg     <= '0;
                count_reg    <= '0;
                cursor_reg   <= row_idx;
                emit_idx_reg <= '0;
            end
            else if (scan_step)
            begin
                done_reg   <= done_reg | pick.onehot;
                count_reg  <= count_reg + bsa_pkg::CNT_BITS'(1);
                cursor_reg <= (pick.idx == bsa_pkg::PROC_BITS'(bsa_pkg::NUM_PROC - 1))
                              ? '0 : pick.idx + bsa_pkg::PROC_BITS'(1);
            end
            else if (emit_step)
            begin
                emit_idx_reg <= emit_idx_reg + bsa_pkg::PROC_BITS'(1);
            end
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (emit)
            out_valid_reg <= 1'b1;
        else if (results.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            status_reg <= emit_status;
            seq_reg    <= emit_seq;
            last_reg   <= emit_last;
        end
    end

    assign results.valid       = out_valid_reg;
    assign results.status      = status_reg;
    assign results.seq_process = seq_reg;
    assign results.last        = last_reg;

    // checks
    a_refusal_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && results.status != bsa_pkg::ST_GRANTED) |-> results.last)
        else $error("non-grant result without last");

    a_scan_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bsa_pkg::S_SCAN) |-> (count_reg < bsa_pkg::CNT_BITS'(bsa_pkg::NUM_PROC)))
        else $error("scan ran past all processes");

    a_pick_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bsa_pkg::S_SCAN && pick.found) |-> $onehot(pick.onehot))
        else $error("merge picked more than one lane");

    a_emit_all_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bsa_pkg::S_EMIT) |-> (&done_reg))
        else $error("safe sequence emitted before all processes finished");

endmodule

// File: sv/bsa_lane.sv
module bsa_lane (
    input  bsa_pkg::row_t      need,
    input  bsa_pkg::row_t      alloc,
    input  bsa_pkg::work_vec_t work,
    input  logic               done,
    input  logic               pick,
    output logic               fits,
    output bsa_pkg::row_t      contrib
);

    // process can finish when every remaining need fits in the work vector
    always_comb
    begin
        fits = !done;
        for (int r = 0; r < bsa_pkg::NUM_RES; r++)
        begin
            if (bsa_pkg::WORK_BITS'(need[r]) > work[r])
                fits = 1'b0;
        end
    end

    // released allocation, only from the chosen lane
    assign contrib = pick ? alloc : '0;

endmodule

// File: sv/bsa_merge.sv
module bsa_merge (
    input  logic [bsa_pkg::NUM_PROC-1:0] fits,
    input  bsa_pkg::proc_t               cursor,
    input  bsa_pkg::row_t                contrib [bsa_pkg::NUM_PROC],
    input  bsa_pkg::work_vec_t           work,
    output bsa_pkg::pick_t               pick,
    output bsa_pkg::work_vec_t           work_sum
);

    logic [bsa_pkg::NUM_PROC-1:0] upper;
    logic [bsa_pkg::NUM_PROC-1:0] cand;
    logic [bsa_pkg::NUM_PROC-1:0] onehot;
    bsa_pkg::row_t                released;

    // first fitting lane at or after the cursor, wrapping around
    always_comb
    begin
        for (int i = 0; i < bsa_pkg::NUM_PROC; i++)
            upper[i] = fits[i] && (bsa_pkg::PROC_BITS'(i) >= cursor);
        cand   = (|upper) ? upper : fits;
        onehot = cand & (~cand + bsa_pkg::NUM_PROC'(1));
    end

    // encode the chosen lane
    always_comb
    begin
        pick.found  = |fits;
        pick.onehot = onehot;
        pick.idx    = '0;
        for (int i = 0; i < bsa_pkg::NUM_PROC; i++)
        begin
            if (onehot[i])
                pick.idx = pick.idx | bsa_pkg::PROC_BITS'(i);
        end
    end

    // add the released allocation to the work vector
    always_comb
    begin
        released = '0;
        for (int i = 0; i < bsa_pkg::NUM_PROC; i++)
            released = released | contrib[i];
        for (int r = 0; r < bsa_pkg::NUM_RES; r++)
            work_sum[r] = work[r] + bsa_pkg::WORK_BITS'(released[r]);
    end

endmodule

// File: bench/tb_bankers_safety_allocator.sv
`timescale 1ns / 1ps

module tb_bankers_safety_allocator;

    localparam int          CLK_HALF     = 6;
    localparam int          RESET_CYCLES = 12;
    localparam int          RANDOM_ITEMS = 270;
    localparam int          HOLD_CYCLES  = 200;
    localparam int          TAIL_CYCLES  = 30;
    localparam logic [1:0]  CMD_SPARE    = 2'd3;
    localparam int          COUNT_MAX    = (1 << bsa_pkg::COUNT_BITS) - 1;

    // one input item
    typedef struct packed {
        logic [1:0]     cmd;
        logic [2:0]     proc_id;
        bsa_pkg::row_t  amount;
        bsa_pkg::row_t  need;
    } req_t;

    // one result item
    typedef struct packed {
        logic [2:0] status;
        logic [2:0] seq_process;
        logic       last;
    } outcome_t;

    logic clk;
    logic rst_n;

    bsa_in_if  items ();
    bsa_out_if results ();

    bankers_safety_allocator u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (items),
        .results (results)
    );

    // predicted resource state
    bsa_pkg::count_t free_pool [bsa_pkg::NUM_RES];
    bsa_pkg::count_t held      [bsa_pkg::NUM_PROC][bsa_pkg::NUM_RES];
    bsa_pkg::count_t owed      [bsa_pkg::NUM_PROC][bsa_pkg::NUM_RES];

    outcome_t pending_results [$];

    int   errors      = 0;
    int   items_sent  = 0;
    bit   offering    = 1'b0;
    bit   tx_idle_on  = 1'b1;
    bit   rx_idle_on  = 1'b1;
    bit   hold_req    = 1'b0;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // run limit
    initial
    begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

    // gap lengths: mostly short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        else if (r < 95)
            return $urandom_range(4, 8);
        else
            return $urandom_range(15, 40);
    endfunction

    function automatic req_t make_item(input logic [1:0] cmd, input int pid,
                                       input int a0, input int a1, input int a2,
                                       input int n0, input int n1, input int n2);
        req_t it;
        it.cmd       = cmd;
        it.proc_id   = pid[2:0];
        it.amount[0] = a0[7:0];
        it.amount[1] = a1[7:0];
        it.amount[2] = a2[7:0];
        it.need[0]   = n0[7:0];
        it.need[1]   = n1[7:0];
        it.need[2]   = n2[7:0];
        return it;
    endfunction

    // expected outcome of one accepted item, tables updated in place
    task automatic predict_outcome(input req_t it);
        bsa_pkg::count_t      amt       [bsa_pkg::NUM_RES];
        bsa_pkg::count_t      save_free [bsa_pkg::NUM_RES];
        bsa_pkg::count_t      save_held [bsa_pkg::NUM_RES];
        bsa_pkg::count_t      save_owed [bsa_pkg::NUM_RES];
        logic [bsa_pkg::COUNT_BITS:0] sum;
        int unsigned work      [bsa_pkg::NUM_RES];
        logic [bsa_pkg::NUM_PROC-1:0] done;
        int          order     [bsa_pkg::NUM_PROC];
        int          finished;
        int          pid;
        int          p;
        bit          progress;
        bit          fits;
        bit          refused;
        pid = int'(it.proc_id);
        for (int r = 0; r < bsa_pkg::NUM_RES; r++)
        begin
            amt[r] = bsa_pkg::count_t'(it.amount[r]);
        end
        case (it.cmd)
            bsa_pkg::CMD_LOAD_ROW:
            begin
                if (pid < bsa_pkg::NUM_PROC)
                begin
                    for (int r = 0; r < bsa_pkg::NUM_RES; r++)
                    begin
                        held[pid][r] = amt[r];
                        owed[pid][r] = bsa_pkg::count_t'(it.need[r]);
                    end
                end
                pending_results.push_back(outcome_t'{bsa_pkg::ST_LOAD_DONE, 3'd0, 1'b1});
            end
            bsa_pkg::CMD_LOAD_FREE:
            begin
                for (int r = 0; r < bsa_pkg::NUM_RES; r++)
                begin
                    free_pool[r] = amt[r];
                end
                pending_results.push_back(outcome_t'{bsa_pkg::ST_LOAD_DONE, 3'd0, 1'b1});
            end
            bsa_pkg::CMD_REQUEST:
            begin
                refused = 1'b0;
                if (pid >= bsa_pkg::NUM_PROC)
                begin
                    refused = 1'b1;
                    pending_results.push_back(outcome_t'{bsa_pkg::ST_OVER_NEED, 3'd0, 1'b1});
                end
                else
                begin
                    for (int r = 0; r < bsa_pkg::NUM_RES; r++)
                    begin
                        if (amt[r] > owed[pid][r])
                            refused = 1'b1;
                    end
                    if (refused)
                        pending_results.push_back(outcome_t'{bsa_pkg::ST_OVER_NEED, 3'd0, 1'b1});
                    else
                    begin
                        for (int r = 0; r < bsa_pkg::NUM_RES; r++)
                        begin
                            if (amt[r] > free_pool[r])
                                refused = 1'b1;
                        end
                        if (refused)
                            pending_results.push_back(outcome_t'{bsa_pkg::ST_NO_FREE, 3'd0, 1'b1});
                    end
                end
                if (!refused)
                begin
                    // tentative grant, allocation saturates
                    for (int r = 0; r < bsa_pkg::NUM_RES; r++)
                    begin
                        save_free[r] = free_pool[r];
                        save_held[r] = held[pid][r];
                        save_owed[r] = owed[pid][r];
                        free_pool[r] = free_pool[r] - amt[r];
                        owed[pid][r] = owed[pid][r] - amt[r];
                        sum = {1'b0, held[pid][r]} + {1'b0, amt[r]};
                        held[pid][r] = (sum > COUNT_MAX) ? bsa_pkg::count_t'(COUNT_MAX)
                                                         : sum[bsa_pkg::COUNT_BITS-1:0];
                    end
                    // safety check: cyclic passes from the requester
                    for (int r = 0; r < bsa_pkg::NUM_RES; r++)
                    begin
                        work[r] = 32'(free_pool[r]);
                    end
                    done     = '0;
                    finished = 0;
                    progress = 1'b1;
                    while (progress && finished < bsa_pkg::NUM_PROC)
                    begin
                        progress = 1'b0;
                        p = pid;
                        for (int n = 0; n < bsa_pkg::NUM_PROC; n++)
                        begin
                            if (!done[p])
                            begin
                                fits = 1'b1;
                                for (int r = 0; r < bsa_pkg::NUM_RES; r++)
                                begin
                                    if (32'(owed[p][r]) > work[r])
                                        fits = 1'b0;
                                end
                                if (fits)
                                begin
                                    for (int r = 0; r < bsa_pkg::NUM_RES; r++)
                                    begin
                                        work[r] += 32'(held[p][r]);
                                    end
                                    done[p] = 1'b1;
                                    order[finished] = p;
                                    finished++;
                                    progress = 1'b1;
                                end
                            end
                            p = (p + 1 == bsa_pkg::NUM_PROC) ? 0 : p + 1;
                        end
                    end
                    if (finished == bsa_pkg::NUM_PROC)
                    begin
                        for (int k = 0; k < bsa_pkg::NUM_PROC; k++)
                        begin
                            pending_results.push_back(outcome_t'{bsa_pkg::ST_GRANTED,
                                3'(order[k]), (k == bsa_pkg::NUM_PROC - 1)});
                        end
                    end
                    else
                    begin
                        // roll back to the exact previous rows
                        for (int r = 0; r < bsa_pkg::NUM_RES; r++)
                        begin
                            free_pool[r] = save_free[r];
                            held[pid][r] = save_held[r];
                            owed[pid][r] = save_owed[r];
                        end
                        pending_results.push_back(outcome_t'{bsa_pkg::ST_UNSAFE, 3'd0, 1'b1});
                    end
                end
            end
            default:
            begin
                pending_results.push_back(outcome_t'{bsa_pkg::ST_LOAD_DONE, 3'd0, 1'b1});
            end
        endcase
    endtask

    // offer one item and wait for its transfer
    task automatic send_item(input req_t it);
        int gap;
        gap = (tx_idle_on && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
        if (!offering || gap > 0)
        begin
            if (offering)
                items.valid <= 1'b0;
            offering = 1'b0;
            repeat ((gap > 0) ? gap : 1) @(posedge clk);
        end
        items.cmd      <= it.cmd;
        items.proc_id  <= it.proc_id;
        items.amount_a <= it.amount[0];
        items.amount_b <= it.amount[1];
        items.amount_c <= it.amount[2];
        items.need_a   <= it.need[0];
        items.need_b   <= it.need[1];
        items.need_c   <= it.need[2];
        items.valid    <= 1'b1;
        offering = 1'b1;
        @(posedge clk);
        while (!items.ready)
            @(posedge clk);
        predict_outcome(it);
        items_sent++;
    endtask

    task automatic release_items();
        if (offering)
            items.valid <= 1'b0;
        offering = 1'b0;
    endtask

    task automatic wait_drain();
        release_items();
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic check_field(input string name, input int expected, input int actual);
        if (expected != actual)
        begin
            $error("%s: expected %0d actual %0d", name, expected, actual);
            errors++;
        end
    endtask

    // result side: check each transfer, then decide next ready
    initial
    begin
        outcome_t exp_out;
        int       hold_left;
        int       gap_left;
        hold_left     = 0;
        gap_left      = 0;
        results.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (results.valid && results.ready)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("result with nothing expected: status %0d seq_process %0d last %0d",
                           results.status, results.seq_process, results.last);
                    errors++;
                end
                else
                begin
                    exp_out = pending_results.pop_front();
                    check_field("status", int'(exp_out.status), int'(results.status));
                    check_field("seq_process", int'(exp_out.seq_process),
                                int'(results.seq_process));
                    check_field("last", int'(exp_out.last), int'(results.last));
                end
            end
            if (hold_req)
            begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0)
            begin
                results.ready <= 1'b0;
                hold_left--;
            end
            else if (gap_left > 0)
            begin
                results.ready <= 1'b0;
                gap_left--;
            end
            else
            begin
                results.ready <= 1'b1;
                if (rx_idle_on && $urandom_range(0, 3) == 0)
                    gap_left = pick_gap();
            end
        end
    end

    // load commands, unused command and out-of-range row
    task automatic test_loads();
        send_item(make_item(bsa_pkg::CMD_LOAD_FREE, 0, 255, 255, 255, 255, 255, 255));
        send_item(make_item(bsa_pkg::CMD_LOAD_ROW, 0, 0, 0, 0, 255, 255, 255));
        send_item(make_item(bsa_pkg::CMD_LOAD_ROW, 7, 255, 255, 255, 255, 255, 255));
        send_item(make_item(CMD_SPARE, 7, 255, 255, 255, 255, 255, 255));
        send_item(make_item(bsa_pkg::CMD_LOAD_ROW, 4, 255, 255, 255, 0, 0, 0));
        wait_drain();
    endtask

    // textbook table and a safe grant
    task automatic test_safe_grant();
        send_item(make_item(bsa_pkg::CMD_LOAD_FREE, 0, 3, 3, 2, 0, 0, 0));
        send_item(make_item(bsa_pkg::CMD_LOAD_ROW, 0, 0, 1, 0, 7, 4, 3));
        send_item(make_item(bsa_pkg::CMD_LOAD_ROW, 1, 2, 0, 0, 1, 2, 2));
        send_item(make_item(bsa_pkg::CMD_LOAD_ROW, 2, 3, 0, 2, 6, 0, 0));
        send_item(make_item(bsa_pkg::CMD_LOAD_ROW, 3, 2, 1, 1, 0, 1, 1));
        send_item(make_item(bsa_pkg::CMD_LOAD_ROW, 4, 0, 0, 2, 4, 3, 1));
        send_item(make_item(bsa_pkg::CMD_REQUEST, 1, 1, 0, 2, 0, 0, 0));
        wait_drain();
    endtask

    // out-of-range process, over need, not enough free
    task automatic test_refusals();
        send_item(make_item(bsa_pkg::CMD_REQUEST, 6, 0, 0, 0, 0, 0, 0));
        send_item(make_item(bsa_pkg::CMD_REQUEST, 4, 5, 0, 0, 0, 0, 0));
        send_item(make_item(bsa_pkg::CMD_REQUEST, 4, 3, 3, 0, 0, 0, 0));
        wait_drain();
    endtask

    // unsafe grant rolled back, then a zero request
    task automatic test_unsafe();
        send_item(make_item(bsa_pkg::CMD_REQUEST, 0, 0, 2, 0, 0, 0, 0));
        send_item(make_item(bsa_pkg::CMD_REQUEST, 2, 0, 0, 0, 0, 0, 0));
        wait_drain();
    endtask

    // allocation saturation on two kept grants, then a zero request
    task automatic test_saturation();
        send_item(make_item(bsa_pkg::CMD_LOAD_FREE, 0, 255, 255, 255, 0, 0, 0));
        send_item(make_item(bsa_pkg::CMD_LOAD_ROW, 2, 250, 255, 0, 10, 0, 255));
        send_item(make_item(bsa_pkg::CMD_REQUEST, 2, 10, 0, 0, 0, 0, 0));
        send_item(make_item(bsa_pkg::CMD_LOAD_ROW, 3, 255, 200, 255, 255, 255, 255));
        send_item(make_item(bsa_pkg::CMD_REQUEST, 3, 1, 1, 1, 0, 0, 0));
        send_item(make_item(bsa_pkg::CMD_REQUEST, 3, 0, 0, 0, 0, 0, 0));
        wait_drain();
    endtask

    // long receiver hold-off while grants keep coming
    task automatic test_backpressure();
        tx_idle_on = 1'b0;
        send_item(make_item(bsa_pkg::CMD_LOAD_FREE, 0, 100, 100, 100, 0, 0, 0));
        for (int p = 0; p < bsa_pkg::NUM_PROC; p++)
        begin
            send_item(make_item(bsa_pkg::CMD_LOAD_ROW, p, 0, 0, 0, 1, 1, 1));
        end
        wait_drain();
        hold_req = 1'b1;
        for (int k = 0; k < 10; k++)
        begin
            send_item(make_item(bsa_pkg::CMD_REQUEST, $urandom_range(0, bsa_pkg::NUM_PROC - 1),
                                $urandom_range(0, 1), 0, $urandom_range(0, 1), 0, 0, 0));
        end
        wait_drain();
        tx_idle_on = 1'b1;
    endtask

    // one scenario: free vector, every row, then requests against it
    task automatic run_episode();
        int span;
        int pid;
        int a [bsa_pkg::NUM_RES];
        int lim;
        int r_sel;
        r_sel = $urandom_range(0, 9);
        span  = (r_sel < 4) ? 7 : (r_sel < 8) ? 31 : 255;
        send_item(make_item(bsa_pkg::CMD_LOAD_FREE, 0, $urandom_range(0, span),
                            $urandom_range(0, span),
                            $urandom_range(0, span), $urandom_range(0, 255),
                            $urandom_range(0, 255), $urandom_range(0, 255)));
        for (int p = 0; p < bsa_pkg::NUM_PROC; p++)
        begin
            send_item(make_item(bsa_pkg::CMD_LOAD_ROW, p, $urandom_range(0, span / 2),
                                $urandom_range(0, span / 2), $urandom_range(0, span / 2),
                                $urandom_range(0, span), $urandom_range(0, span),
                                $urandom_range(0, span)));
        end
        repeat ($urandom_range(4, 10))
        begin
            if ($urandom_range(0, 7) != 0)
            begin
                // well-formed: within need and free
                pid = $urandom_range(0, bsa_pkg::NUM_PROC - 1);
                for (int r = 0; r < bsa_pkg::NUM_RES; r++)
                begin
                    lim  = (owed[pid][r] < free_pool[r]) ? int'(owed[pid][r])
                                                         : int'(free_pool[r]);
                    a[r] = $urandom_range(0, lim);
                end
                send_item(make_item(bsa_pkg::CMD_REQUEST, pid, a[0], a[1], a[2],
                                    $urandom_range(0, 255), $urandom_range(0, 255),
                                    $urandom_range(0, 255)));
            end
            else
            begin
                send_item(make_item(bsa_pkg::CMD_REQUEST, $urandom_range(0, 7),
                                    $urandom_range(0, span),
                                    $urandom_range(0, span), $urandom_range(0, span),
                                    $urandom_range(0, 255), $urandom_range(0, 255),
                                    $urandom_range(0, 255)));
            end
        end
    endtask

    // random scenarios mixed with noise items
    task automatic test_random();
        int start_count;
        start_count = items_sent;
        while (items_sent - start_count < RANDOM_ITEMS)
        begin
            tx_idle_on = ($urandom_range(0, 3) != 0);
            rx_idle_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 9) < 8)
                run_episode();
            else
            begin
                repeat ($urandom_range(1, 4))
                begin
                    send_item(make_item(2'($urandom_range(0, 3)), $urandom_range(0, 7),
                                        $urandom_range(0, 255), $urandom_range(0, 255),
                                        $urandom_range(0, 255), $urandom_range(0, 255),
                                        $urandom_range(0, 255), $urandom_range(0, 255)));
                end
            end
        end
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    // reset, tests in turn, final verdict
    initial
    begin
        for (int r = 0; r < bsa_pkg::NUM_RES; r++)
        begin
            free_pool[r] = '0;
            for (int p = 0; p < bsa_pkg::NUM_PROC; p++)
            begin
                held[p][r] = '0;
                owed[p][r] = '0;
            end
        end
        rst_n          = 1'b0;
        items.valid    = 1'b0;
        items.cmd      = bsa_pkg::CMD_LOAD_ROW;
        items.proc_id  = '0;
        items.amount_a = '0;
        items.amount_b = '0;
        items.amount_c = '0;
        items.need_a   = '0;
        items.need_b   = '0;
        items.need_c   = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_loads();
        test_safe_grant();
        test_refusals();
        test_unsafe();
        test_saturation();
        test_backpressure();
        test_random();

        wait_drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
